FILE: sv/ssmcs_pkg.sv
package ssmcs_pkg;

   // Field widths
   localparam int CMD_W     = 3;
   localparam int ADDR_W    = 24;
   localparam int COUNT_W   = 25;
   localparam int BYTE_W    = 8;
   localparam int KIND_W    = 3;
   localparam int PTR_W     = 25;   // internal address pointer, one bit above the bus address
   localparam int CHUNK_W   = 9;
   localparam int MODE_W    = 2;
   localparam int MAX_RES   = 8;
   localparam int RES_CNT_W = 4;
   localparam int RES_IDX_W = 3;

   // Request commands
   localparam logic [CMD_W-1:0] CMD_READ_START   = 3'd0;
   localparam logic [CMD_W-1:0] CMD_WRITE_START  = 3'd1;
   localparam logic [CMD_W-1:0] CMD_WRITE_DATA   = 3'd2;
   localparam logic [CMD_W-1:0] CMD_SECTOR_ERASE = 3'd3;
   localparam logic [CMD_W-1:0] CMD_PAGE_ERASE   = 3'd4;
   localparam logic [CMD_W-1:0] CMD_CHIP_ERASE   = 3'd5;
   localparam logic [CMD_W-1:0] CMD_BUS_REPLY    = 3'd6;

   // Response kinds
   localparam logic [KIND_W-1:0] KIND_SEND    = 3'd0;
   localparam logic [KIND_W-1:0] KIND_RELEASE = 3'd1;
   localparam logic [KIND_W-1:0] KIND_DATA    = 3'd2;
   localparam logic [KIND_W-1:0] KIND_DONE    = 3'd3;
   localparam logic [KIND_W-1:0] KIND_REJECT  = 3'd4;

   // SPI opcodes
   localparam logic [BYTE_W-1:0] OP_READ         = 8'h03;
   localparam logic [BYTE_W-1:0] OP_PROGRAM      = 8'h02;
   localparam logic [BYTE_W-1:0] OP_WREN         = 8'h06;
   localparam logic [BYTE_W-1:0] OP_READ_STATUS  = 8'h05;
   localparam logic [BYTE_W-1:0] OP_SECTOR_ERASE = 8'hD8;
   localparam logic [BYTE_W-1:0] OP_PAGE_ERASE   = 8'h81;
   localparam logic [BYTE_W-1:0] OP_CHIP_ERASE   = 8'hC7;
   localparam logic [BYTE_W-1:0] DUMMY_BYTE      = 8'h00;
   localparam int                STATUS_WIP_BIT  = 0;

   // Address modes
   localparam logic [MODE_W-1:0] MODE_NONE  = 2'd0;
   localparam logic [MODE_W-1:0] MODE_1BYTE = 2'd1;
   localparam logic [MODE_W-1:0] MODE_2BYTE = 2'd2;
   localparam logic [MODE_W-1:0] MODE_3BYTE = 2'd3;

   typedef enum logic [2:0] {
      PH_IDLE,
      PH_READ,
      PH_WDATA,
      PH_STATUS,
      PH_POLL
   } phase_type;

   typedef struct packed {
      phase_type            phase;
      logic [PTR_W-1:0]     current_address;
      logic [PTR_W-1:0]     end_address;
      logic [CHUNK_W-1:0]   chunk_count;
      logic [COUNT_W-1:0]   remaining_reads;
      logic                 busy_op_is_write;
   } state_type;

   typedef struct packed {
      logic [CMD_W-1:0]   command;
      logic [ADDR_W-1:0]  mem_address;
      logic [COUNT_W-1:0] byte_count;
      logic [BYTE_W-1:0]  write_byte;
      logic [BYTE_W-1:0]  reply_byte;
   } req_item_type;

   typedef struct packed {
      logic [KIND_W-1:0] kind;
      logic [BYTE_W-1:0] byte_value;
      logic              expect_reply;
   } res_type;

   typedef res_type [MAX_RES-1:0] res_list_type;

   typedef struct packed {
      res_list_type         list;
      logic [RES_CNT_W-1:0] count;
   } seq_type;

endpackage

FILE: sv/ssmcs_req_if.sv
interface ssmcs_req_if;
   logic                            valid;
   logic                            ready;
   logic [ssmcs_pkg::CMD_W-1:0]     command;
   logic [ssmcs_pkg::ADDR_W-1:0]    mem_address;
   logic [ssmcs_pkg::COUNT_W-1:0]   byte_count;
   logic [ssmcs_pkg::BYTE_W-1:0]    write_byte;
   logic [ssmcs_pkg::BYTE_W-1:0]    reply_byte;

   modport source (
      output valid, command, mem_address, byte_count, write_byte, reply_byte,
      input  ready
   );

   modport sink (
      input  valid, command, mem_address, byte_count, write_byte, reply_byte,
      output ready
   );
endinterface

FILE: sv/ssmcs_rsp_if.sv
interface ssmcs_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [ssmcs_pkg::KIND_W-1:0]  kind;
   logic [ssmcs_pkg::BYTE_W-1:0]  byte_value;
   logic                          expect_reply;
   logic                          last;

   modport source (
      output valid, kind, byte_value, expect_reply, last,
      input  ready
   );

   modport sink (
      input  valid, kind, byte_value, expect_reply, last,
      output ready
   );
endinterface

FILE: sv/ssmcs_plan.sv
// Builds the full response list and next sequencer state for one request.
module ssmcs_plan #(
   parameter int PAGE_SMALL  = 16,
   parameter int PAGE_MEDIUM = 32,
   parameter int PAGE_LARGE  = 256
) (
   input  ssmcs_pkg::state_type                state,
   input  ssmcs_pkg::req_item_type             item,
   input  logic [ssmcs_pkg::MODE_W-1:0]        addr_mode,
   output ssmcs_pkg::res_list_type             res_list,
   output logic [ssmcs_pkg::RES_CNT_W-1:0]     res_count,
   output ssmcs_pkg::state_type                state_next
);

   // Append one response to the list
   function automatic ssmcs_pkg::seq_type push(
      ssmcs_pkg::seq_type                 s,
      logic [ssmcs_pkg::KIND_W-1:0]       kind,
      logic [ssmcs_pkg::BYTE_W-1:0]       value,
      logic                               expect_reply
   );
      ssmcs_pkg::seq_type r;
      r = s;
      if (s.count < ssmcs_pkg::RES_CNT_W'(ssmcs_pkg::MAX_RES)) begin
         r.list[s.count[ssmcs_pkg::RES_IDX_W-1:0]].kind         = kind;
         r.list[s.count[ssmcs_pkg::RES_IDX_W-1:0]].byte_value   = value;
         r.list[s.count[ssmcs_pkg::RES_IDX_W-1:0]].expect_reply = expect_reply;
         r.count = s.count + 1'b1;
      end
      return r;
   endfunction

   // Opcode plus address bytes; 1-byte mode folds A8 into opcode bit 3
   function automatic ssmcs_pkg::seq_type push_cmd_addr(
      ssmcs_pkg::seq_type                 s,
      logic [ssmcs_pkg::BYTE_W-1:0]       opcode,
      logic [ssmcs_pkg::ADDR_W-1:0]       a,
      logic [ssmcs_pkg::MODE_W-1:0]       m
   );
      ssmcs_pkg::seq_type r;
      r = s;
      if (m == ssmcs_pkg::MODE_1BYTE) begin
         r = push(r, ssmcs_pkg::KIND_SEND, opcode | {4'b0000, a[8], 3'b000}, 1'b0);
      end else begin
         r = push(r, ssmcs_pkg::KIND_SEND, opcode, 1'b0);
         if (m == ssmcs_pkg::MODE_3BYTE) begin
            r = push(r, ssmcs_pkg::KIND_SEND, a[23:16], 1'b0);
         end
         r = push(r, ssmcs_pkg::KIND_SEND, a[15:8], 1'b0);
      end
      r = push(r, ssmcs_pkg::KIND_SEND, a[7:0], 1'b0);
      return r;
   endfunction

   // WREN, release, program opcode and address
   function automatic ssmcs_pkg::seq_type push_chunk(
      ssmcs_pkg::seq_type                 s,
      logic [ssmcs_pkg::PTR_W-1:0]        cur,
      logic [ssmcs_pkg::MODE_W-1:0]       m
   );
      ssmcs_pkg::seq_type r;
      r = push(s, ssmcs_pkg::KIND_SEND, ssmcs_pkg::OP_WREN, 1'b0);
      r = push(r, ssmcs_pkg::KIND_RELEASE, '0, 1'b0);
      r = push_cmd_addr(r, ssmcs_pkg::OP_PROGRAM, cur[ssmcs_pkg::ADDR_W-1:0], m);
      return r;
   endfunction

   ssmcs_pkg::seq_type                  seq;
   ssmcs_pkg::state_type                nx;
   logic                                ok;
   logic [ssmcs_pkg::MODE_W-1:0]        mode;
   logic [ssmcs_pkg::CHUNK_W-1:0]       page;
   logic [ssmcs_pkg::PTR_W:0]           end_sum;
   logic [ssmcs_pkg::PTR_W-1:0]         cur_inc;
   logic [ssmcs_pkg::CHUNK_W-1:0]       chunk_inc;
   logic [ssmcs_pkg::COUNT_W-1:0]       reads_dec;

   // Effective mode and page size
   always_comb begin
      mode = (addr_mode == ssmcs_pkg::MODE_NONE) ? ssmcs_pkg::MODE_1BYTE : addr_mode;
      case (mode)
         ssmcs_pkg::MODE_1BYTE: page = ssmcs_pkg::CHUNK_W'(PAGE_SMALL);
         ssmcs_pkg::MODE_2BYTE: page = ssmcs_pkg::CHUNK_W'(PAGE_MEDIUM);
         default:               page = ssmcs_pkg::CHUNK_W'(PAGE_LARGE);
      endcase
   end

   // Arithmetic shared by the phases
   always_comb begin
      end_sum   = {2'b00, item.mem_address} + {1'b0, item.byte_count};
      cur_inc   = state.current_address + 1'b1;
      chunk_inc = state.chunk_count + 1'b1;
      reads_dec = state.remaining_reads - 1'b1;
   end

   // Response list and next state
   always_comb begin
      seq = '0;
      nx  = state;
      ok  = 1'b0;
      case (state.phase)
         ssmcs_pkg::PH_IDLE: begin
            if (item.command == ssmcs_pkg::CMD_READ_START) begin
               ok  = 1'b1;
               seq = push_cmd_addr(seq, ssmcs_pkg::OP_READ, item.mem_address, mode);
               if (item.byte_count == '0) begin
                  seq = push(seq, ssmcs_pkg::KIND_RELEASE, '0, 1'b0);
                  seq = push(seq, ssmcs_pkg::KIND_DONE, '0, 1'b0);
                  nx.phase = ssmcs_pkg::PH_IDLE;
               end else begin
                  nx.remaining_reads = item.byte_count;
                  seq = push(seq, ssmcs_pkg::KIND_SEND, ssmcs_pkg::DUMMY_BYTE, 1'b1);
                  nx.phase = ssmcs_pkg::PH_READ;
               end
            end else if (item.command == ssmcs_pkg::CMD_WRITE_START) begin
               ok = 1'b1;
               nx.current_address  = {1'b0, item.mem_address};
               nx.end_address      = end_sum[ssmcs_pkg::PTR_W] ? '1
                                     : end_sum[ssmcs_pkg::PTR_W-1:0];
               nx.busy_op_is_write = 1'b1;
               if (nx.current_address >= nx.end_address) begin
                  seq = push(seq, ssmcs_pkg::KIND_DONE, '0, 1'b0);
                  nx.phase = ssmcs_pkg::PH_IDLE;
               end else begin
                  seq = push_chunk(seq, nx.current_address, mode);
                  nx.chunk_count = '0;
                  nx.phase = ssmcs_pkg::PH_WDATA;
               end
            end else if (item.command inside {ssmcs_pkg::CMD_SECTOR_ERASE,
                                              ssmcs_pkg::CMD_PAGE_ERASE,
                                              ssmcs_pkg::CMD_CHIP_ERASE}) begin
               ok = 1'b1;
               nx.busy_op_is_write = 1'b0;
               seq = push(seq, ssmcs_pkg::KIND_SEND, ssmcs_pkg::OP_WREN, 1'b0);
               seq = push(seq, ssmcs_pkg::KIND_RELEASE, '0, 1'b0);
               if (item.command == ssmcs_pkg::CMD_CHIP_ERASE) begin
                  seq = push(seq, ssmcs_pkg::KIND_SEND, ssmcs_pkg::OP_CHIP_ERASE, 1'b0);
               end else begin
                  seq = push(seq, ssmcs_pkg::KIND_SEND,
                             (item.command == ssmcs_pkg::CMD_SECTOR_ERASE)
                                ? ssmcs_pkg::OP_SECTOR_ERASE : ssmcs_pkg::OP_PAGE_ERASE,
                             1'b0);
                  seq = push(seq, ssmcs_pkg::KIND_SEND, item.mem_address[23:16], 1'b0);
                  seq = push(seq, ssmcs_pkg::KIND_SEND, item.mem_address[15:8], 1'b0);
                  seq = push(seq, ssmcs_pkg::KIND_SEND, item.mem_address[7:0], 1'b0);
               end
               seq = push(seq, ssmcs_pkg::KIND_RELEASE, '0, 1'b0);
               seq = push(seq, ssmcs_pkg::KIND_SEND, ssmcs_pkg::OP_READ_STATUS, 1'b1);
               nx.phase = ssmcs_pkg::PH_STATUS;
            end
         end
         ssmcs_pkg::PH_WDATA: begin
            if (item.command == ssmcs_pkg::CMD_WRITE_DATA) begin
               ok = 1'b1;
               seq = push(seq, ssmcs_pkg::KIND_SEND, item.write_byte, 1'b0);
               nx.current_address = cur_inc;
               nx.chunk_count     = chunk_inc;
               // chunk ends at the end address or after one page worth of bytes
               if (cur_inc >= state.end_address || chunk_inc >= page) begin
                  nx.busy_op_is_write = 1'b1;
                  seq = push(seq, ssmcs_pkg::KIND_RELEASE, '0, 1'b0);
                  seq = push(seq, ssmcs_pkg::KIND_SEND, ssmcs_pkg::OP_READ_STATUS, 1'b1);
                  nx.phase = ssmcs_pkg::PH_STATUS;
               end
            end
         end
         ssmcs_pkg::PH_READ: begin
            if (item.command == ssmcs_pkg::CMD_BUS_REPLY) begin
               ok = 1'b1;
               seq = push(seq, ssmcs_pkg::KIND_DATA, item.reply_byte, 1'b0);
               nx.remaining_reads = reads_dec;
               if (reads_dec != '0) begin
                  seq = push(seq, ssmcs_pkg::KIND_SEND, ssmcs_pkg::DUMMY_BYTE, 1'b1);
               end else begin
                  seq = push(seq, ssmcs_pkg::KIND_RELEASE, '0, 1'b0);
                  seq = push(seq, ssmcs_pkg::KIND_DONE, '0, 1'b0);
                  nx.phase = ssmcs_pkg::PH_IDLE;
               end
            end
         end
         ssmcs_pkg::PH_STATUS: begin
            // reply to the status opcode itself only paces the sequence
            if (item.command == ssmcs_pkg::CMD_BUS_REPLY) begin
               ok = 1'b1;
               seq = push(seq, ssmcs_pkg::KIND_SEND, ssmcs_pkg::DUMMY_BYTE, 1'b1);
               nx.phase = ssmcs_pkg::PH_POLL;
            end
         end
         ssmcs_pkg::PH_POLL: begin
            if (item.command == ssmcs_pkg::CMD_BUS_REPLY) begin
               ok = 1'b1;
               if (item.reply_byte[ssmcs_pkg::STATUS_WIP_BIT]) begin
                  seq = push(seq, ssmcs_pkg::KIND_SEND, ssmcs_pkg::DUMMY_BYTE, 1'b1);
               end else begin
                  seq = push(seq, ssmcs_pkg::KIND_RELEASE, '0, 1'b0);
                  if (state.busy_op_is_write &&
                      state.current_address < state.end_address) begin
                     seq = push_chunk(seq, state.current_address, mode);
                     nx.chunk_count = '0;
                     nx.phase = ssmcs_pkg::PH_WDATA;
                  end else begin
                     seq = push(seq, ssmcs_pkg::KIND_DONE, '0, 1'b0);
                     nx.phase = ssmcs_pkg::PH_IDLE;
                  end
               end
            end
         end
         default: begin
            ok = 1'b0;
         end
      endcase

      // out-of-phase command: single reject, state untouched
      if (!ok) begin
         seq = push('0, ssmcs_pkg::KIND_REJECT, '0, 1'b0);
         nx  = state;
      end
   end

   assign res_list   = seq.list;
   assign res_count  = seq.count;
   assign state_next = nx;

endmodule

FILE: sv/spi_save_memory_command_sequencer.sv
// Channel  | Direction | Contents
// ---------+-----------+--------------------------------------------------------
// req_ch   | in        | command, mem_address, byte_count, write_byte, reply_byte
// rsp_ch   | out       | kind, byte_value, expect_reply, last (one per transaction)
// csr_*    | in        | addr_mode write (write enable + 2-bit data)
//
// A request is registered, then expanded combinationally into a list of 1 to 8
// responses that are loaded into a response buffer, which offers the first one.
// Responses leave one per cycle while rsp_ch is ready, so a request occupies the
// output port for one transfer per response (1 to 8); the next request is
// taken while the buffer drains. Reset is synchronous; no clearing pass.
// Backpressure on rsp_ch stalls the buffer, then the input register, then req_ch.
module spi_save_memory_command_sequencer #(
   parameter int PAGE_SMALL  = 16,
   parameter int PAGE_MEDIUM = 32,
   parameter int PAGE_LARGE  = 256
) (
   input  logic                          clock,
   input  logic                          reset,
   ssmcs_req_if.sink                     req_ch,
   ssmcs_rsp_if.source                   rsp_ch,
   input  logic                          csr_write_enable,
   input  logic [ssmcs_pkg::MODE_W-1:0]  csr_write_data
);

   ssmcs_pkg::state_type                  state_ff, state_in, state_next;
   ssmcs_pkg::req_item_type               item_ff, item_in;
   logic                                  item_valid_ff, item_valid_in;
   ssmcs_pkg::res_list_type               list_ff, list_in, plan_list;
   logic [ssmcs_pkg::RES_CNT_W-1:0]       count_ff, count_in, plan_count;
   logic [ssmcs_pkg::RES_IDX_W-1:0]       pos_ff, pos_in;
   logic                                  buf_valid_ff, buf_valid_in;
   logic [ssmcs_pkg::MODE_W-1:0]          mode_ff, mode_in;

   logic                                  in_take;
   logic                                  in_ready;
   logic                                  rsp_fire;
   logic                                  at_last;
   logic                                  buf_done;
   logic                                  buf_load;

   // Response list builder
   ssmcs_plan #(
      .PAGE_SMALL  (PAGE_SMALL),
      .PAGE_MEDIUM (PAGE_MEDIUM),
      .PAGE_LARGE  (PAGE_LARGE)
   ) u_plan (
      .state      (state_ff),
      .item       (item_ff),
      .addr_mode  (mode_ff),
      .res_list   (plan_list),
      .res_count  (plan_count),
      .state_next (state_next)
   );

   // Handshake control
   always_comb begin
      at_last  = ({1'b0, pos_ff} + 1'b1) == count_ff;
      rsp_fire = buf_valid_ff & rsp_ch.ready;
      buf_done = rsp_fire & at_last;
      buf_load = item_valid_ff & (~buf_valid_ff | buf_done);
      in_ready = ~item_valid_ff | buf_load;
      in_take  = req_ch.valid & in_ready;
   end

   // Next-value logic
   always_comb begin
      item_in       = item_ff;
      item_valid_in = in_take | (item_valid_ff & ~buf_load);
      if (in_take) begin
         item_in.command     = req_ch.command;
         item_in.mem_address = req_ch.mem_address;
         item_in.byte_count  = req_ch.byte_count;
         item_in.write_byte  = req_ch.write_byte;
         item_in.reply_byte  = req_ch.reply_byte;
      end

      list_in      = buf_load ? plan_list : list_ff;
      count_in     = buf_load ? plan_count : count_ff;
      state_in     = buf_load ? state_next : state_ff;
      buf_valid_in = buf_load | (buf_valid_ff & ~buf_done);

      if (buf_load) begin
         pos_in = '0;
      end else if (rsp_fire) begin
         pos_in = pos_ff + 1'b1;
      end else begin
         pos_in = pos_ff;
      end

      mode_in = csr_write_enable ? csr_write_data : mode_ff;
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= '{phase: ssmcs_pkg::PH_IDLE, default: '0};
         item_valid_ff <= 1'b0;
         buf_valid_ff  <= 1'b0;
         pos_ff        <= '0;
         mode_ff       <= ssmcs_pkg::MODE_3BYTE;
      end else begin
         state_ff      <= state_in;
         item_valid_ff <= item_valid_in;
         buf_valid_ff  <= buf_valid_in;
         pos_ff        <= pos_in;
         mode_ff       <= mode_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      item_ff  <= item_in;
      list_ff  <= list_in;
      count_ff <= count_in;
   end

   // Port drive
   assign req_ch.ready        = in_ready;
   assign rsp_ch.valid        = buf_valid_ff;
   assign rsp_ch.kind         = list_ff[pos_ff].kind;
   assign rsp_ch.byte_value   = list_ff[pos_ff].byte_value;
   assign rsp_ch.expect_reply = list_ff[pos_ff].expect_reply;
   assign rsp_ch.last         = at_last;

endmodule

FILE: tb/spi_save_memory_command_sequencer_tb.sv
module spi_save_memory_command_sequencer_tb;

   localparam int PAGE_SMALL  = 16;
   localparam int PAGE_MEDIUM = 32;
   localparam int PAGE_LARGE  = 256;
   localparam logic [2:0] CMD_UNUSED = 3'd7;

   // expected response transaction
   typedef struct {
      logic [ssmcs_pkg::KIND_W-1:0] kind;
      logic [ssmcs_pkg::BYTE_W-1:0] byte_value;
      logic                         expect_reply;
      logic                         last;
   } spi_rsp_type;

   // request waiting for the driver
   typedef struct {
      ssmcs_pkg::req_item_type rq;
      bit                      drain_first;
   } pend_req_type;

   // sequencer state as tracked by the testbench
   typedef struct {
      ssmcs_pkg::phase_type          ph;
      logic [ssmcs_pkg::PTR_W-1:0]   cur_addr;
      logic [ssmcs_pkg::PTR_W-1:0]   end_addr;
      logic [ssmcs_pkg::CHUNK_W-1:0] chunk;
      logic [ssmcs_pkg::COUNT_W-1:0] reads_left;
      logic                          op_is_write;
   } seq_track_type;

   logic clock;
   logic reset = 1'b1;
   logic                         csr_write_enable = 1'b0;
   logic [ssmcs_pkg::MODE_W-1:0] csr_write_data = ssmcs_pkg::MODE_3BYTE;

   ssmcs_req_if req_bus ();
   ssmcs_rsp_if rsp_bus ();

   spi_save_memory_command_sequencer dut (
      .clock            (clock),
      .reset            (reset),
      .req_ch           (req_bus),
      .rsp_ch           (rsp_bus),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   spi_rsp_type  spi_rsp_expected [$];
   pend_req_type req_pending [$];

   // tracked state: one copy follows accepted requests, one plans the stimulus
   seq_track_type                dut_track = '{ssmcs_pkg::PH_IDLE, '0, '0, '0, '0, 1'b0};
   seq_track_type                plan_track = '{ssmcs_pkg::PH_IDLE, '0, '0, '0, '0, 1'b0};
   logic [ssmcs_pkg::MODE_W-1:0] dut_mode = ssmcs_pkg::MODE_3BYTE;
   logic [ssmcs_pkg::MODE_W-1:0] plan_mode = ssmcs_pkg::MODE_3BYTE;

   // scratch used while expanding one request
   seq_track_type                trk;
   logic [ssmcs_pkg::MODE_W-1:0] trk_mode;
   spi_rsp_type                  rsp_buf [ssmcs_pkg::MAX_RES];
   int                           rsp_cnt;

   int req_issued = 0;
   int req_accepted = 0;
   int reject_count = 0;
   int rsp_checked = 0;
   int mismatch_count = 0;
   int send_idle_pct = 0;
   int rsp_stall_pct = 0;

   function automatic logic [7:0] rand8();
      return 8'($urandom);
   endfunction

   function automatic logic [23:0] rand24();
      return 24'($urandom);
   endfunction

   function automatic logic [24:0] rand25();
      return 25'($urandom);
   endfunction

   // ---------------- request expansion ----------------
   function automatic void add_rsp(input logic [ssmcs_pkg::KIND_W-1:0] k,
                                   input logic [7:0] v, input logic er);
      if (rsp_cnt < ssmcs_pkg::MAX_RES) begin
         rsp_buf[rsp_cnt].kind = k;
         rsp_buf[rsp_cnt].byte_value = v;
         rsp_buf[rsp_cnt].expect_reply = er;
         rsp_buf[rsp_cnt].last = 1'b0;
         rsp_cnt++;
      end
   endfunction

   function automatic logic [ssmcs_pkg::MODE_W-1:0] eff_mode(
      input logic [ssmcs_pkg::MODE_W-1:0] m);
      return (m == ssmcs_pkg::MODE_NONE) ? ssmcs_pkg::MODE_1BYTE : m;
   endfunction

   function automatic int page_limit(input logic [ssmcs_pkg::MODE_W-1:0] m);
      case (eff_mode(m))
         ssmcs_pkg::MODE_2BYTE: return PAGE_MEDIUM;
         ssmcs_pkg::MODE_3BYTE: return PAGE_LARGE;
         default:               return PAGE_SMALL;
      endcase
   endfunction

   // opcode plus address bytes; 1-byte mode folds address bit 8 into opcode bit 3
   function automatic void send_cmd_addr(input logic [7:0] op,
                                         input logic [ssmcs_pkg::PTR_W-1:0] a);
      logic [ssmcs_pkg::MODE_W-1:0] m;
      m = eff_mode(trk_mode);
      if (m == ssmcs_pkg::MODE_1BYTE) begin
         add_rsp(ssmcs_pkg::KIND_SEND, op | {4'b0, a[8], 3'b0}, 1'b0);
      end else begin
         add_rsp(ssmcs_pkg::KIND_SEND, op, 1'b0);
         if (m == ssmcs_pkg::MODE_3BYTE) add_rsp(ssmcs_pkg::KIND_SEND, a[23:16], 1'b0);
         add_rsp(ssmcs_pkg::KIND_SEND, a[15:8], 1'b0);
      end
      add_rsp(ssmcs_pkg::KIND_SEND, a[7:0], 1'b0);
   endfunction

   function automatic void open_chunk();
      add_rsp(ssmcs_pkg::KIND_SEND, ssmcs_pkg::OP_WREN, 1'b0);
      add_rsp(ssmcs_pkg::KIND_RELEASE, 8'h00, 1'b0);
      send_cmd_addr(ssmcs_pkg::OP_PROGRAM, trk.cur_addr);
      trk.chunk = '0;
      trk.ph = ssmcs_pkg::PH_WDATA;
   endfunction

   function automatic void open_status_poll();
      add_rsp(ssmcs_pkg::KIND_RELEASE, 8'h00, 1'b0);
      add_rsp(ssmcs_pkg::KIND_SEND, ssmcs_pkg::OP_READ_STATUS, 1'b1);
      trk.ph = ssmcs_pkg::PH_STATUS;
   endfunction

   function automatic void close_op();
      add_rsp(ssmcs_pkg::KIND_DONE, 8'h00, 1'b0);
      trk.ph = ssmcs_pkg::PH_IDLE;
   endfunction

   // expands one request against trk / trk_mode into rsp_buf[0 .. rsp_cnt-1]
   function automatic void expand_request(input ssmcs_pkg::req_item_type rq);
      logic [25:0] span_end;
      logic        ok;
      rsp_cnt = 0;
      ok = 1'b1;
      if (trk.ph == ssmcs_pkg::PH_IDLE && rq.command == ssmcs_pkg::CMD_READ_START) begin
         send_cmd_addr(ssmcs_pkg::OP_READ, {1'b0, rq.mem_address});
         if (rq.byte_count == '0) begin
            add_rsp(ssmcs_pkg::KIND_RELEASE, 8'h00, 1'b0);
            close_op();
         end else begin
            trk.reads_left = rq.byte_count;
            add_rsp(ssmcs_pkg::KIND_SEND, ssmcs_pkg::DUMMY_BYTE, 1'b1);
            trk.ph = ssmcs_pkg::PH_READ;
         end
      end else if (trk.ph == ssmcs_pkg::PH_IDLE &&
                   rq.command == ssmcs_pkg::CMD_WRITE_START) begin
         // end address saturates at the top of the 25-bit pointer
         span_end = {2'b0, rq.mem_address} + {1'b0, rq.byte_count};
         trk.cur_addr = {1'b0, rq.mem_address};
         trk.end_addr = (span_end > 26'h1FFFFFF) ? 25'h1FFFFFF : span_end[24:0];
         trk.op_is_write = 1'b1;
         if (trk.cur_addr >= trk.end_addr) close_op();
         else open_chunk();
      end else if (trk.ph == ssmcs_pkg::PH_IDLE &&
                   rq.command >= ssmcs_pkg::CMD_SECTOR_ERASE &&
                   rq.command <= ssmcs_pkg::CMD_CHIP_ERASE) begin
         trk.op_is_write = 1'b0;
         add_rsp(ssmcs_pkg::KIND_SEND, ssmcs_pkg::OP_WREN, 1'b0);
         add_rsp(ssmcs_pkg::KIND_RELEASE, 8'h00, 1'b0);
         if (rq.command == ssmcs_pkg::CMD_CHIP_ERASE) begin
            add_rsp(ssmcs_pkg::KIND_SEND, ssmcs_pkg::OP_CHIP_ERASE, 1'b0);
         end else begin
            add_rsp(ssmcs_pkg::KIND_SEND, (rq.command == ssmcs_pkg::CMD_SECTOR_ERASE) ?
                    ssmcs_pkg::OP_SECTOR_ERASE : ssmcs_pkg::OP_PAGE_ERASE, 1'b0);
            add_rsp(ssmcs_pkg::KIND_SEND, rq.mem_address[23:16], 1'b0);
            add_rsp(ssmcs_pkg::KIND_SEND, rq.mem_address[15:8], 1'b0);
            add_rsp(ssmcs_pkg::KIND_SEND, rq.mem_address[7:0], 1'b0);
         end
         open_status_poll();
      end else if (trk.ph == ssmcs_pkg::PH_WDATA &&
                   rq.command == ssmcs_pkg::CMD_WRITE_DATA) begin
         add_rsp(ssmcs_pkg::KIND_SEND, rq.write_byte, 1'b0);
         trk.cur_addr = trk.cur_addr + 1'b1;
         trk.chunk = trk.chunk + 1'b1;
         if (trk.cur_addr >= trk.end_addr || trk.chunk >= 9'(page_limit(trk_mode))) begin
            trk.op_is_write = 1'b1;
            open_status_poll();
         end
      end else if (rq.command == ssmcs_pkg::CMD_BUS_REPLY &&
                   trk.ph == ssmcs_pkg::PH_READ) begin
         add_rsp(ssmcs_pkg::KIND_DATA, rq.reply_byte, 1'b0);
         trk.reads_left = trk.reads_left - 1'b1;
         if (trk.reads_left != '0) begin
            add_rsp(ssmcs_pkg::KIND_SEND, ssmcs_pkg::DUMMY_BYTE, 1'b1);
         end else begin
            add_rsp(ssmcs_pkg::KIND_RELEASE, 8'h00, 1'b0);
            close_op();
         end
      end else if (rq.command == ssmcs_pkg::CMD_BUS_REPLY &&
                   trk.ph == ssmcs_pkg::PH_STATUS) begin
         // reply to the status opcode only paces the sequence
         add_rsp(ssmcs_pkg::KIND_SEND, ssmcs_pkg::DUMMY_BYTE, 1'b1);
         trk.ph = ssmcs_pkg::PH_POLL;
      end else if (rq.command == ssmcs_pkg::CMD_BUS_REPLY &&
                   trk.ph == ssmcs_pkg::PH_POLL) begin
         if (rq.reply_byte[ssmcs_pkg::STATUS_WIP_BIT]) begin
            add_rsp(ssmcs_pkg::KIND_SEND, ssmcs_pkg::DUMMY_BYTE, 1'b1);
         end else begin
            add_rsp(ssmcs_pkg::KIND_RELEASE, 8'h00, 1'b0);
            if (trk.op_is_write && trk.cur_addr < trk.end_addr) open_chunk();
            else close_op();
         end
      end else begin
         ok = 1'b0;
      end
      if (!ok) add_rsp(ssmcs_pkg::KIND_REJECT, 8'h00, 1'b0);
      rsp_buf[rsp_cnt-1].last = 1'b1;
   endfunction

   // ---------------- stimulus planning ----------------
   function automatic void queue_req(input logic [2:0] cmd, input logic [23:0] addr,
                                     input logic [24:0] cnt, input logic [7:0] wb,
                                     input logic [7:0] rb, input bit drain);
      pend_req_type p;
      p.rq.command = cmd;
      p.rq.mem_address = addr;
      p.rq.byte_count = cnt;
      p.rq.write_byte = wb;
      p.rq.reply_byte = rb;
      p.drain_first = drain;
      trk = plan_track;
      trk_mode = plan_mode;
      expand_request(p.rq);
      plan_track = trk;
      req_pending.push_back(p);
   endfunction

   function automatic bit plan_rejects(input ssmcs_pkg::req_item_type rq);
      trk = plan_track;
      trk_mode = plan_mode;
      expand_request(rq);
      return rsp_buf[0].kind == ssmcs_pkg::KIND_REJECT;
   endfunction

   // out-of-phase transaction with random fields
   function automatic void queue_noise();
      ssmcs_pkg::req_item_type rq;
      bit                      found;
      found = 1'b0;
      for (int i = 0; i < 32 && !found; i++) begin
         rq.command = 3'($urandom_range(7));
         rq.mem_address = rand24();
         rq.byte_count = rand25();
         rq.write_byte = rand8();
         rq.reply_byte = rand8();
         if (plan_rejects(rq)) begin
            queue_req(rq.command, rq.mem_address, rq.byte_count, rq.write_byte,
                      rq.reply_byte, 1'b0);
            found = 1'b1;
         end
      end
   endfunction

   function automatic void queue_op_start();
      logic [2:0]  cmd;
      logic [23:0] addr;
      logic [24:0] cnt;
      int          r;
      int          pg;
      r = $urandom_range(99);
      addr = rand24();
      cnt = '0;
      pg = page_limit(plan_mode);
      if (r < 30) begin
         cmd = ssmcs_pkg::CMD_READ_START;
         cnt = ($urandom_range(9) == 0) ? 25'd0 : 25'($urandom_range(1, 6));
      end else if (r < 60) begin
         cmd = ssmcs_pkg::CMD_WRITE_START;
         if ($urandom_range(5) == 0) addr = 24'hFFFFFF - 24'($urandom_range(20));
         cnt = (pg == PAGE_LARGE) ? 25'($urandom_range(0, 24)) :
               25'($urandom_range(0, pg + 8));
      end else if (r < 75) begin
         cmd = ssmcs_pkg::CMD_SECTOR_ERASE;
      end else if (r < 88) begin
         cmd = ssmcs_pkg::CMD_PAGE_ERASE;
      end else begin
         cmd = ssmcs_pkg::CMD_CHIP_ERASE;
      end
      queue_req(cmd, addr, cnt, rand8(), rand8(), $urandom_range(9) == 0);
   endfunction

   function automatic void queue_follow_up();
      logic [7:0] rb;
      rb = rand8();
      if (plan_track.ph == ssmcs_pkg::PH_WDATA) begin
         queue_req(ssmcs_pkg::CMD_WRITE_DATA, rand24(), rand25(), rand8(), rb, 1'b0);
      end else begin
         if (plan_track.ph == ssmcs_pkg::PH_POLL)
            rb[ssmcs_pkg::STATUS_WIP_BIT] = ($urandom_range(99) < 40);
         queue_req(ssmcs_pkg::CMD_BUS_REPLY, rand24(), rand25(), rand8(), rb, 1'b0);
      end
   endfunction

   // whole operations with random content, each run back to idle
   function automatic void plan_random_ops(input int target);
      int made;
      made = 0;
      while (made < target) begin
         if ($urandom_range(99) < 8) queue_noise();
         queue_op_start();
         made++;
         while (plan_track.ph != ssmcs_pkg::PH_IDLE) begin
            if ($urandom_range(99) < 6) queue_noise();
            queue_follow_up();
            made++;
         end
      end
   endfunction

   function automatic void plan_directed();
      // empty read, empty write, then a two-byte read and a two-byte write
      queue_req(ssmcs_pkg::CMD_READ_START, 24'hABCDEF, 25'd0, 8'h00, 8'h00, 1'b0);
      queue_req(ssmcs_pkg::CMD_WRITE_START, 24'h123456, 25'd0, 8'h00, 8'h00, 1'b0);
      queue_req(ssmcs_pkg::CMD_READ_START, 24'hFFFFFF, 25'd2, 8'h00, 8'h00, 1'b0);
      queue_req(ssmcs_pkg::CMD_BUS_REPLY, 24'h000000, 25'd0, 8'h00, 8'hFF, 1'b0);
      queue_req(ssmcs_pkg::CMD_BUS_REPLY, 24'hFFFFFF, 25'h1FFFFFF, 8'hFF, 8'h00, 1'b0);
      queue_req(ssmcs_pkg::CMD_WRITE_START, 24'h000000, 25'd2, 8'h00, 8'h00, 1'b0);
      queue_req(ssmcs_pkg::CMD_WRITE_DATA, 24'h000000, 25'd0, 8'hFF, 8'h00, 1'b0);
      queue_req(ssmcs_pkg::CMD_WRITE_DATA, 24'h000000, 25'd0, 8'h00, 8'h00, 1'b0);
      // status handshake, still busy, ready
      queue_req(ssmcs_pkg::CMD_BUS_REPLY, 24'h000000, 25'd0, 8'h00, 8'h5A, 1'b0);
      queue_req(ssmcs_pkg::CMD_BUS_REPLY, 24'h000000, 25'd0, 8'h00, 8'h01, 1'b0);
      queue_req(ssmcs_pkg::CMD_BUS_REPLY, 24'h000000, 25'd0, 8'h00, 8'hFE, 1'b0);
      // hold off until the write has fully drained
      queue_req(ssmcs_pkg::CMD_SECTOR_ERASE, 24'h00FF00, 25'd0, 8'h00, 8'h00, 1'b1);
      queue_req(ssmcs_pkg::CMD_BUS_REPLY, 24'h000000, 25'd0, 8'h00, 8'h00, 1'b0);
      queue_req(ssmcs_pkg::CMD_BUS_REPLY, 24'h000000, 25'd0, 8'h00, 8'h00, 1'b0);
      queue_req(ssmcs_pkg::CMD_PAGE_ERASE, 24'hFFFFFF, 25'd0, 8'h00, 8'h00, 1'b0);
      queue_req(ssmcs_pkg::CMD_BUS_REPLY, 24'h000000, 25'd0, 8'h00, 8'hFF, 1'b0);
      queue_req(ssmcs_pkg::CMD_BUS_REPLY, 24'h000000, 25'd0, 8'h00, 8'h00, 1'b0);
      queue_req(ssmcs_pkg::CMD_CHIP_ERASE, 24'h000000, 25'd0, 8'h00, 8'h00, 1'b0);
      queue_req(ssmcs_pkg::CMD_BUS_REPLY, 24'h000000, 25'd0, 8'h00, 8'h00, 1'b0);
      queue_req(ssmcs_pkg::CMD_BUS_REPLY, 24'h000000, 25'd0, 8'h00, 8'hFF, 1'b0);
      queue_req(ssmcs_pkg::CMD_BUS_REPLY, 24'h000000, 25'd0, 8'h00, 8'h00, 1'b0);
      // out of phase while idle
      queue_req(ssmcs_pkg::CMD_WRITE_DATA, 24'h000000, 25'd0, 8'hA5, 8'h00, 1'b0);
      queue_req(ssmcs_pkg::CMD_BUS_REPLY, 24'h000000, 25'd0, 8'h00, 8'h3C, 1'b0);
      queue_req(CMD_UNUSED, 24'hFFFFFF, 25'h1FFFFFF, 8'hFF, 8'hFF, 1'b0);
   endfunction

   // saturating end address; the first chunk crosses the 24-bit wrap, then a second chunk opens
   function automatic void plan_overflow_write();
      queue_req(ssmcs_pkg::CMD_WRITE_START, 24'hFFFFF8, 25'h1FFFFFF, 8'h00, 8'h00, 1'b0);
      while (plan_track.ph == ssmcs_pkg::PH_WDATA) queue_follow_up();
      queue_req(ssmcs_pkg::CMD_BUS_REPLY, 24'h000000, 25'd0, 8'h00, 8'h00, 1'b0);
      queue_req(ssmcs_pkg::CMD_BUS_REPLY, 24'h000000, 25'd0, 8'h00, 8'h00, 1'b0);
      for (int i = 0; i < 3; i++) queue_follow_up();
   endfunction

   function automatic logic [ssmcs_pkg::MODE_W-1:0] mode_for_phase(input int p);
      case (p)
         1, 7:    return ssmcs_pkg::MODE_1BYTE;
         2, 5:    return ssmcs_pkg::MODE_NONE;
         3, 6:    return ssmcs_pkg::MODE_2BYTE;
         default: return ssmcs_pkg::MODE_3BYTE;
      endcase
   endfunction

   task automatic set_flow(input int prof);
      case (prof)
         1: begin
            send_idle_pct = 51;
            rsp_stall_pct = 0;
         end
         2: begin
            send_idle_pct = 0;
            rsp_stall_pct = 51;
         end
         3: begin
            send_idle_pct = 31;
            rsp_stall_pct = 31;
         end
         default: begin
            send_idle_pct = 0;
            rsp_stall_pct = 0;
         end
      endcase
   endtask

   task automatic wait_drained();
      while (!(req_pending.size() == 0 && req_accepted == req_issued &&
               spi_rsp_expected.size() == 0))
         @(posedge clock);
   endtask

   task automatic write_mode(input logic [ssmcs_pkg::MODE_W-1:0] m);
      @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data <= m;
      dut_mode = m;
      plan_mode = m;
      @(negedge clock);
      csr_write_enable <= 1'b0;
   endtask

   // ---------------- clock ----------------
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // ---------------- request driver ----------------
   always @(negedge clock) begin : req_driver
      pend_req_type head;
      if (reset) begin
         req_bus.valid <= 1'b0;
      end else if (req_bus.valid && req_accepted != req_issued) begin
         // transaction still offered, hold it
      end else if (req_pending.size() != 0 && $urandom_range(99) >= send_idle_pct &&
                   (!req_pending[0].drain_first || spi_rsp_expected.size() == 0)) begin
         head = req_pending.pop_front();
         req_bus.valid <= 1'b1;
         req_bus.command <= head.rq.command;
         req_bus.mem_address <= head.rq.mem_address;
         req_bus.byte_count <= head.rq.byte_count;
         req_bus.write_byte <= head.rq.write_byte;
         req_bus.reply_byte <= head.rq.reply_byte;
         req_issued++;
      end else begin
         req_bus.valid <= 1'b0;
      end
   end

   // response backpressure
   always @(negedge clock) begin
      if (reset) rsp_bus.ready <= 1'b0;
      else rsp_bus.ready <= ($urandom_range(99) >= rsp_stall_pct);
   end

   // ---------------- monitor and scoreboard ----------------
   always @(posedge clock) begin : rsp_monitor
      ssmcs_pkg::req_item_type seen;
      spi_rsp_type             want;
      if (!reset) begin
         // accepted request: predict its responses
         if (req_bus.valid && req_bus.ready) begin
            seen.command = req_bus.command;
            seen.mem_address = req_bus.mem_address;
            seen.byte_count = req_bus.byte_count;
            seen.write_byte = req_bus.write_byte;
            seen.reply_byte = req_bus.reply_byte;
            trk = dut_track;
            trk_mode = dut_mode;
            expand_request(seen);
            dut_track = trk;
            for (int i = 0; i < rsp_cnt; i++) spi_rsp_expected.push_back(rsp_buf[i]);
            if (rsp_buf[0].kind == ssmcs_pkg::KIND_REJECT) reject_count++;
            req_accepted++;
         end
         // accepted response: compare with oldest prediction
         if (rsp_bus.valid && rsp_bus.ready) begin
            rsp_checked++;
            if (spi_rsp_expected.size() == 0) begin
               mismatch_count++;
               $display("%0t: unexpected response kind=%0d byte=%02h er=%0b last=%0b",
                        $time, rsp_bus.kind, rsp_bus.byte_value, rsp_bus.expect_reply,
                        rsp_bus.last);
            end else begin
               want = spi_rsp_expected.pop_front();
               if (rsp_bus.kind !== want.kind || rsp_bus.byte_value !== want.byte_value ||
                   rsp_bus.expect_reply !== want.expect_reply ||
                   rsp_bus.last !== want.last) begin
                  mismatch_count++;
                  $display("%0t: want k=%0d b=%02h e=%0b l=%0b got k=%0d b=%02h e=%0b l=%0b",
                           $time, want.kind, want.byte_value, want.expect_reply, want.last,
                           rsp_bus.kind, rsp_bus.byte_value, rsp_bus.expect_reply,
                           rsp_bus.last);
               end
            end
         end
      end
   end

   // ---------------- test sequence ----------------
   initial begin : stimulus
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      for (int p = 0; p < 8; p++) begin
         if (p > 0) begin
            wait_drained();
            repeat (8) @(posedge clock);
            write_mode(mode_for_phase(p));
         end
         set_flow(p % 4);
         if (p == 0) plan_directed();
         else plan_random_ops(18);
      end
      plan_overflow_write();
      wait_drained();
      repeat (20) @(posedge clock);
      $display("checked %0d responses for %0d requests (%0d rejected)",
               rsp_checked, req_accepted, reject_count);
      $display("address modes 0-3 under no, sender, receiver and mixed flow-control gaps");
      if (mismatch_count == 0 && spi_rsp_expected.size() == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

   // watchdog
   initial begin
      #5000000;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule
